### rtl/dq_pkg.sv
// Shared definitions for the double-ended queue core.
// Request codes, the request code width and the control state encoding.
package dq_pkg;

   localparam int REQ_BITS = 3;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_QUERY      = 3'd0,
      REQ_PUSH_FRONT = 3'd1,
      REQ_PUSH_BACK  = 3'd2,
      REQ_POP_FRONT  = 3'd3,
      REQ_POP_BACK   = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FETCH = 2'b10
   } state_type;

endpackage

### rtl/dq_if.sv
// Valid/ready channel interfaces for the double-ended queue core.
// Depends on dq_pkg for the request code width.
interface dq_req_if #(
   parameter int WORD_BITS = 32
);
   logic                                valid;
   logic                                ready;
   logic [dq_pkg::REQ_BITS-1:0]         req_type;
   logic signed [WORD_BITS-1:0]         push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface dq_rsp_if #(
   parameter int WORD_BITS = 32,
   parameter int CNT_BITS  = 14
);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] popped_value;
   logic                        pop_valid;
   logic                        request_error;
   logic [CNT_BITS-1:0]         entry_count;
   logic                        is_empty;
   logic signed [WORD_BITS-1:0] front_value;
   logic signed [WORD_BITS-1:0] back_value;

   modport source (output valid, output popped_value, output pop_valid,
                   output request_error, output entry_count, output is_empty,
                   output front_value, output back_value, input ready);
   modport sink   (input valid, input popped_value, input pop_valid,
                   input request_error, input entry_count, input is_empty,
                   input front_value, input back_value, output ready);
endinterface

### rtl/double_ended_queue_core.sv
// Double-ended queue of signed words in a circular RAM, top level.
// Depends on dq_pkg, dq_req_if, dq_rsp_if and dq_ram.
//
// Usage:
//   req_bus carries one request per beat: req_type (query, push front, push
//   back, pop front, pop back; unused codes act as query) and push_value.
//   rsp_bus returns exactly one beat per request: popped word, pop_valid,
//   request_error (pop on empty, push on full), entry count, empty flag and
//   the front and back words after the request (zero when empty).
//   The front and back words are cached in registers; the RAM holds the body.
// Response timing:
//   Query, push, and pops that leave at most one word: the result goes
//   straight into the output register, and the next request can be taken
//   as it drains. Pops that leave two or more words first read the new end
//   word from the RAM in ST_FETCH; no request is taken during ST_FETCH.
// Reset: head index and count clear, the queue is empty. The RAM is not
//   cleared; only written entries are ever read.
// Stall: the result sits in an output register; a new request is taken
//   while it is being drained, and held off while rsp_bus.ready stays low.
module double_ended_queue_core #(
   parameter int DEPTH     = 8192,
   parameter int WORD_BITS = 32
) (
   input logic     clock,
   input logic     reset,
   dq_req_if.sink  req_bus,
   dq_rsp_if.source rsp_bus
);
   import dq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [AW-1:0] wrap_idx(input logic [CW:0] s);
      logic [CW:0] r;
      r = (s >= (CW+1)'(DEPTH)) ? s - (CW+1)'(DEPTH) : s;
      return r[AW-1:0];
   endfunction

   state_type                   state_ff, state_in;
   logic [AW-1:0]               head_ff, head_in;
   logic [CW-1:0]               count_ff, count_in;
   logic signed [WORD_BITS-1:0] front_ff, front_in;
   logic signed [WORD_BITS-1:0] back_ff, back_in;
   logic                        fetch_back_ff, fetch_back_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_BITS-1:0] popped_ff, popped_in;
   logic                        pop_valid_ff, pop_valid_in;
   logic                        error_ff, error_in;
   logic [CW-1:0]               cnt_out_ff, cnt_out_in;
   logic signed [WORD_BITS-1:0] front_out_ff, front_out_in;
   logic signed [WORD_BITS-1:0] back_out_ff, back_out_in;

   logic                        req_fire;
   logic                        full, empty;
   logic [AW-1:0]               head_dec, head_inc, tail_push, back_prev;
   logic                        wr_en, rd_en;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic [WORD_BITS-1:0]        rd_data;

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign full      = count_ff == CW'(DEPTH);
   assign empty     = count_ff == '0;
   assign head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc  = wrap_idx((CW+1)'(head_ff) + (CW+1)'(1));
   assign tail_push = wrap_idx((CW+1)'(head_ff) + (CW+1)'(count_ff));
   assign back_prev = wrap_idx((CW+1)'(head_ff) + (CW+1)'(count_ff) - (CW+1)'(2));

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      fetch_back_in = fetch_back_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      popped_in     = popped_ff;
      pop_valid_in  = pop_valid_ff;
      error_in      = error_ff;
      cnt_out_in    = cnt_out_ff;
      front_out_in  = front_out_ff;
      back_out_in   = back_out_ff;
      wr_en         = 1'b0;
      wr_addr       = head_dec;
      rd_en         = 1'b0;
      rd_addr       = head_inc;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               popped_in    = '0;
               pop_valid_in = 1'b0;
               error_in     = 1'b0;
               unique case (req_code_type'(req_bus.req_type))
                  REQ_PUSH_FRONT: begin
                     if (full) begin
                        error_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        head_in  = head_dec;
                        count_in = count_ff + CW'(1);
                        front_in = req_bus.push_value;
                        if (empty) back_in = req_bus.push_value;
                     end
                  end
                  REQ_PUSH_BACK: begin
                     if (full) begin
                        error_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = tail_push;
                        count_in = count_ff + CW'(1);
                        back_in  = req_bus.push_value;
                        if (empty) front_in = req_bus.push_value;
                     end
                  end
                  REQ_POP_FRONT: begin
                     if (empty) begin
                        error_in = 1'b1;
                     end else begin
                        popped_in    = front_ff;
                        pop_valid_in = 1'b1;
                        head_in      = head_inc;
                        count_in     = count_ff - CW'(1);
                        if (count_ff == CW'(2)) begin
                           front_in = back_ff;
                        end else if (count_ff > CW'(2)) begin
                           rd_en         = 1'b1;
                           rd_addr       = head_inc;
                           fetch_back_in = 1'b0;
                           state_in      = ST_FETCH;
                        end
                     end
                  end
                  REQ_POP_BACK: begin
                     if (empty) begin
                        error_in = 1'b1;
                     end else begin
                        popped_in    = back_ff;
                        pop_valid_in = 1'b1;
                        count_in     = count_ff - CW'(1);
                        if (count_ff == CW'(2)) begin
                           back_in = front_ff;
                        end else if (count_ff > CW'(2)) begin
                           rd_en         = 1'b1;
                           rd_addr       = back_prev;
                           fetch_back_in = 1'b1;
                           state_in      = ST_FETCH;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               cnt_out_in   = count_in;
               front_out_in = (count_in == '0) ? '0 : front_in;
               back_out_in  = (count_in == '0) ? '0 : back_in;
               rsp_valid_in = (state_in == ST_IDLE);
            end
         end
         ST_FETCH: begin
            if (fetch_back_ff) begin
               back_in = rd_data;
            end else begin
               front_in = rd_data;
            end
            front_out_in = front_in;
            back_out_in  = back_in;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      back_ff       <= back_in;
      fetch_back_ff <= fetch_back_in;
      popped_ff     <= popped_in;
      pop_valid_ff  <= pop_valid_in;
      error_ff      <= error_in;
      cnt_out_ff    <= cnt_out_in;
      front_out_ff  <= front_out_in;
      back_out_ff   <= back_out_in;
   end

   dq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_bus.push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.popped_value  = popped_ff;
   assign rsp_bus.pop_valid     = pop_valid_ff;
   assign rsp_bus.request_error = error_ff;
   assign rsp_bus.entry_count   = cnt_out_ff;
   assign rsp_bus.is_empty      = cnt_out_ff == '0;
   assign rsp_bus.front_value   = front_out_ff;
   assign rsp_bus.back_value    = back_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   a_fetch_after_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> $past(req_fire) && !rsp_valid_ff)
      else $error("fetch without a pop beat or with result pending");

   a_pop_err_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(pop_valid_ff && error_ff))
      else $error("pop reported both valid and error");

   a_fetch_returns: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("fetch did not complete in one cycle");

endmodule

### rtl/dq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
